@@ hw/rtl/psov_pkg.sv @@
// shared types and constants for the premultiplied source-over compositor
`timescale 1ns / 1ps

package psov_pkg;

	localparam int ChanW      = 16;
	localparam int NumChan    = 4;
	localparam int OpacityW   = 17;
	localparam int QDepth     = 4;
	localparam int QPtrW      = $clog2(QDepth);
	localparam int QCntW      = $clog2(QDepth + 1);

	localparam int ChanRed    = 0;
	localparam int ChanGreen  = 1;
	localparam int ChanBlue   = 2;
	localparam int ChanAlpha  = 3;

	localparam logic [OpacityW-1:0] OpacityOne = OpacityW'(65536);
	localparam logic [ChanW-1:0]    ChanMax    = {ChanW{1'b1}};

	typedef logic [ChanW-1:0] chan_t;
	typedef chan_t [NumChan-1:0] pix_t;

	// scaled source and destination, handed from front to back
	typedef struct packed {
		pix_t src;
		pix_t dst;
	} job_t;

	// push or pop side of the job queue
	typedef struct packed {
		logic valid;
		job_t job;
	} job_req_t;

endpackage

@@ hw/rtl/psov_if.sv @@
// request channel interfaces for input and result pixels
`timescale 1ns / 1ps

interface psov_in_if;
	logic        valid;
	logic        ready;
	logic        covered;
	logic [15:0] src_red;
	logic [15:0] src_green;
	logic [15:0] src_blue;
	logic [15:0] src_alpha;
	logic [15:0] dst_red;
	logic [15:0] dst_green;
	logic [15:0] dst_blue;
	logic [15:0] dst_alpha;

	modport source (
		output valid, covered, src_red, src_green, src_blue, src_alpha,
		output dst_red, dst_green, dst_blue, dst_alpha,
		input  ready
	);
	modport sink (
		input  valid, covered, src_red, src_green, src_blue, src_alpha,
		input  dst_red, dst_green, dst_blue, dst_alpha,
		output ready
	);
endinterface

interface psov_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] out_red;
	logic [15:0] out_green;
	logic [15:0] out_blue;
	logic [15:0] out_alpha;

	modport source (
		output valid, out_red, out_green, out_blue, out_alpha,
		input  ready
	);
	modport sink (
		input  valid, out_red, out_green, out_blue, out_alpha,
		output ready
	);
endinterface

@@ hw/rtl/psov_front.sv @@
// front: opacity register, request intake and source opacity scaling
`timescale 1ns / 1ps

module psov_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [psov_pkg::OpacityW-1:0]    cfg_wr_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic                             in_covered,
	input  psov_pkg::pix_t                   in_src,
	input  psov_pkg::pix_t                   in_dst,
	output psov_pkg::job_req_t               push,
	input  logic                             push_ready
);
	import psov_pkg::*;

	logic [OpacityW-1:0] opacity_q;
	logic [OpacityW-1:0] op_sat;
	logic                v_s1;
	logic [31:0]         prod_s1 [NumChan];
	pix_t                dst_s1;
	logic [31:0]         rnd [NumChan];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			opacity_q <= OpacityOne;
		end else if (cfg_wr_en) begin
			opacity_q <= cfg_wr_data;
		end
	end

	assign op_sat   = (opacity_q > OpacityOne) ? OpacityOne : opacity_q;
	assign in_ready = !v_s1 || push_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	// uncovered pixels get a zero source, so the blend returns dst exactly
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			for (int i = 0; i < NumChan; i++) begin
				prod_s1[i] <= in_covered ? (32'(in_src[i]) * 32'(op_sat)) : 32'd0;
			end
			dst_s1 <= in_dst;
		end
	end

	// rounded product never exceeds the channel max
	always_comb begin
		push.valid   = v_s1;
		push.job.dst = dst_s1;
		for (int i = 0; i < NumChan; i++) begin
			rnd[i]          = prod_s1[i] + 32'd32768;
			push.job.src[i] = rnd[i][31:16];
		end
	end

endmodule

@@ hw/rtl/psov_queue.sv @@
// short job queue between front and back
`timescale 1ns / 1ps

module psov_queue (
	input  logic                   clk,
	input  logic                   arst_n,
	input  psov_pkg::job_req_t     push,
	output logic                   push_ready,
	output psov_pkg::job_req_t     pop,
	input  logic                   pop_ready
);
	import psov_pkg::*;

	job_t              mem_q [QDepth];
	logic [QPtrW-1:0]  wr_ptr_q;
	logic [QPtrW-1:0]  rd_ptr_q;
	logic [QCntW-1:0]  count_q;
	logic              do_push;
	logic              do_pop;

	assign push_ready = (count_q != QCntW'(QDepth));
	assign pop.valid  = (count_q != '0);
	assign pop.job    = mem_q[rd_ptr_q];
	assign do_push    = push.valid && push_ready;
	assign do_pop     = pop.valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push.job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ hw/rtl/psov_back.sv @@
// back: destination weighting, divide by channel max, saturate, result register
`timescale 1ns / 1ps

module psov_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  psov_pkg::job_req_t   pop,
	output logic                 pop_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	output psov_pkg::pix_t       out_pix
);
	import psov_pkg::*;

	chan_t        inv;
	logic         v_s1;
	logic [31:0]  prod_s1 [NumChan];
	pix_t         src_s1;
	logic         v_s2;
	pix_t         pix_s2;
	logic         adv_out;
	logic [31:0]  y    [NumChan];
	logic [15:0]  q0   [NumChan];
	logic [16:0]  r0   [NumChan];
	logic [16:0]  quo  [NumChan];
	logic [16:0]  sum  [NumChan];
	pix_t         blend;

	assign inv       = ~pop.job.src[ChanAlpha];
	assign adv_out   = !v_s2 || out_ready;
	assign pop_ready = !v_s1 || adv_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (pop_ready) begin
				v_s1 <= pop.valid;
			end
			if (adv_out) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop_ready && pop.valid) begin
			for (int i = 0; i < NumChan; i++) begin
				prod_s1[i] <= 32'(pop.job.dst[i]) * 32'(inv);
			end
			src_s1 <= pop.job.src;
		end
	end

	// (p + 32767) / 65535 via the 65536 split and one correction step
	always_comb begin
		for (int i = 0; i < NumChan; i++) begin
			y[i]     = prod_s1[i] + 32'd32767;
			q0[i]    = y[i][31:16];
			r0[i]    = {1'b0, y[i][15:0]} + {1'b0, q0[i]};
			quo[i]   = {1'b0, q0[i]} + ((r0[i] >= {1'b0, ChanMax}) ? 17'd1 : 17'd0);
			sum[i]   = {1'b0, src_s1[i]} + quo[i];
			blend[i] = sum[i][16] ? ChanMax : sum[i][15:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv_out && v_s1) begin
			pix_s2 <= blend;
		end
	end

	assign out_valid = v_s2;
	assign out_pix   = pix_s2;

endmodule

@@ hw/rtl/premul_rgba16_source_over.sv @@
// top level of the premultiplied 16-bit rgba source-over compositor
//
//  channel   | dir | handshake          | contents
//  pix_in    | in  | valid/ready        | covered, src rgba, dst rgba
//  pix_out   | out | valid/ready        | composited rgba
//  cfg_wr_*  | in  | write enable/data  | layer opacity, 17 bits
//
// one pixel per clock sustained while pix_out.ready stays high; an accepted request passes the registers below
// path to pix_out: front product register, queue entry, back product register, result register
// reset clears the valid flags and queue pointers and sets opacity to fully opaque
// the front and back stall on their own; the four-entry queue absorbs the difference
`timescale 1ns / 1ps

module premul_rgba16_source_over (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [psov_pkg::OpacityW-1:0] cfg_wr_data,
	psov_in_if.sink                       pix_in,
	psov_out_if.source                    pix_out
);
	import psov_pkg::*;

	pix_t     in_src;
	pix_t     in_dst;
	pix_t     out_pix;
	job_req_t push;
	job_req_t pop;
	logic     push_ready;
	logic     pop_ready;

	assign in_src[ChanRed]   = pix_in.src_red;
	assign in_src[ChanGreen] = pix_in.src_green;
	assign in_src[ChanBlue]  = pix_in.src_blue;
	assign in_src[ChanAlpha] = pix_in.src_alpha;
	assign in_dst[ChanRed]   = pix_in.dst_red;
	assign in_dst[ChanGreen] = pix_in.dst_green;
	assign in_dst[ChanBlue]  = pix_in.dst_blue;
	assign in_dst[ChanAlpha] = pix_in.dst_alpha;

	psov_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid   (pix_in.valid),
		.in_ready   (pix_in.ready),
		.in_covered (pix_in.covered),
		.in_src     (in_src),
		.in_dst     (in_dst),
		.push       (push),
		.push_ready (push_ready)
	);

	psov_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_ready(push_ready),
		.pop       (pop),
		.pop_ready (pop_ready)
	);

	psov_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.pop      (pop),
		.pop_ready(pop_ready),
		.out_valid(pix_out.valid),
		.out_ready(pix_out.ready),
		.out_pix  (out_pix)
	);

	assign pix_out.out_red   = out_pix[ChanRed];
	assign pix_out.out_green = out_pix[ChanGreen];
	assign pix_out.out_blue  = out_pix[ChanBlue];
	assign pix_out.out_alpha = out_pix[ChanAlpha];

endmodule
